// File: src/lzwc_pkg.sv
// Shared types and constants for the LZW byte stream compressor.
`timescale 1ns / 1ps

package lzwc_pkg;

    localparam int BYTE_W     = 8;
    localparam int CODE_W     = 16;
    localparam int KEY_W      = CODE_W + BYTE_W;
    localparam int EPOCH_W    = 8;
    localparam int FIRST_CODE = 256;

    typedef logic [EPOCH_W-1:0] t_epoch;

    // One dictionary entry. A tag that differs from the current epoch marks it empty;
    // tag zero is never a live epoch.
    typedef struct packed {
        t_epoch            tag;
        logic [CODE_W-1:0] key_prefix;
        logic [BYTE_W-1:0] key_byte;
        logic [CODE_W-1:0] code;
    } t_dict_entry;

    localparam int ENTRY_W = $bits(t_dict_entry);

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_CHECK,
        ST_EMIT_OLD,
        ST_EMIT_LAST
    } t_state;

endpackage

// File: src/lzwc_dict_ram.sv
// Dictionary memory: one write port, one read port, registered read data.
`timescale 1ns / 1ps

module lzwc_dict_ram #(
    parameter int ADDR_W = 16
) (
    input  logic                      i_clk,
    input  logic                      i_we,
    input  logic [ADDR_W-1:0]         i_waddr,
    input  lzwc_pkg::t_dict_entry     i_wdata,
    input  logic [ADDR_W-1:0]         i_raddr,
    output lzwc_pkg::t_dict_entry     o_rdata
);

    lzwc_pkg::t_dict_entry r_mem [2**ADDR_W];
    lzwc_pkg::t_dict_entry r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// File: src/lzw_byte_stream_compressor.sv
// LZW compressor top level: control sequencer, prefix state and output register.
//
// Input channel: one raw byte per word (i_data_byte), with i_stream_end on the last
// byte of a stream. A word is taken when i_in_valid is high and o_in_stall is low.
// Output channel: one 16-bit code per word (o_code_word), o_code_last on the final
// code of a stream; taken when o_out_valid is high and i_out_stall is low.
// Dictionary: hashed table of 2**ceil(log2(DICT_SIZE)) entries in one synchronous
// RAM, linear probing one slot per cycle. Codes are handed out from 256 up to
// DICT_SIZE-1, then the table stops growing until the stream ends.
// Per byte: the first byte of a stream is taken in IDLE and becomes the prefix; a hit
// passes through CHECK, a miss through CHECK and EMIT_OLD, with one more CHECK per extra
// probe on a collision; a stream-end byte adds EMIT_LAST for the final code. The
// registered RAM read sets the per-probe cost. Output: a code is loaded into the
// output register in EMIT_OLD or EMIT_LAST, after the probes of its byte.
// While the receiver stalls a full output register, the sequencer waits at its next
// code and stops taking bytes.
// Reset: a clearing pass writes every RAM entry, with the input stalled. Stream ends flip
// an 8-bit epoch so the table empties at once; every 255th stream end the epoch wraps
// and the same clearing pass runs.
`timescale 1ns / 1ps

module lzw_byte_stream_compressor #(
    parameter int DICT_SIZE = 65536
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  logic [lzwc_pkg::BYTE_W-1:0]   i_data_byte,
    input  logic                          i_stream_end,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic [lzwc_pkg::CODE_W-1:0]   o_code_word,
    output logic                          o_code_last
);

    localparam int AW        = $clog2(DICT_SIZE);
    localparam int CW        = $clog2(DICT_SIZE + 1);
    localparam int NCHUNK    = (lzwc_pkg::KEY_W + AW - 1) / AW;
    localparam int KEY_EXT_W = NCHUNK * AW;

    // Fold the key into a slot index.
    function automatic logic [AW-1:0] slot_hash(input logic [lzwc_pkg::KEY_W-1:0] key);
        logic [KEY_EXT_W-1:0] ext;
        logic [AW-1:0]        h;
        ext = KEY_EXT_W'(key);
        h   = '0;
        for (int i = 0; i < NCHUNK; i++) begin
            h = h ^ ext[i*AW +: AW];
        end
        return h;
    endfunction

    lzwc_pkg::t_state                r_state, n_state;
    logic [lzwc_pkg::BYTE_W-1:0]     r_byte, n_byte;
    logic                            r_last, n_last;
    logic [AW-1:0]                   r_slot, n_slot;
    logic [lzwc_pkg::CODE_W-1:0]     r_prefix, n_prefix;
    logic                            r_held, n_held;
    logic [CW-1:0]                   r_next_code, n_next_code;
    lzwc_pkg::t_epoch                r_epoch, n_epoch;
    logic [AW-1:0]                   r_clr_addr, n_clr_addr;
    logic                            r_out_valid, n_out_valid;
    logic [lzwc_pkg::CODE_W-1:0]     r_out_code, n_out_code;
    logic                            r_out_last, n_out_last;

    logic                            w_accept;
    logic                            w_can_load;
    logic                            w_we;
    logic [AW-1:0]                   w_waddr;
    lzwc_pkg::t_dict_entry           w_wdata;
    logic [AW-1:0]                   w_raddr;
    lzwc_pkg::t_dict_entry           w_rdata;
    logic                            w_entry_live;
    logic                            w_key_match;

    lzwc_dict_ram #(
        .ADDR_W (AW)
    ) u_dict_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    assign o_in_stall  = (r_state != lzwc_pkg::ST_IDLE);
    assign w_accept    = i_in_valid && !o_in_stall;
    assign w_can_load  = !r_out_valid || !i_out_stall;
    assign w_entry_live = (w_rdata.tag == r_epoch);
    assign w_key_match  = (w_rdata.key_prefix == r_prefix) && (w_rdata.key_byte == r_byte);

    always_comb begin
        n_state     = r_state;
        n_byte      = r_byte;
        n_last      = r_last;
        n_slot      = r_slot;
        n_prefix    = r_prefix;
        n_held      = r_held;
        n_next_code = r_next_code;
        n_epoch     = r_epoch;
        n_clr_addr  = r_clr_addr;
        n_out_valid = r_out_valid && i_out_stall;
        n_out_code  = r_out_code;
        n_out_last  = r_out_last;
        w_we        = 1'b0;
        w_waddr     = r_slot;
        w_wdata     = '{tag: r_epoch, key_prefix: r_prefix, key_byte: r_byte,
                        code: lzwc_pkg::CODE_W'(r_next_code)};
        w_raddr     = r_slot + AW'(1);

        unique case (r_state)
            lzwc_pkg::ST_CLEAR: begin
                w_we       = 1'b1;
                w_waddr    = r_clr_addr;
                w_wdata    = '0;
                n_clr_addr = r_clr_addr + AW'(1);
                if (r_clr_addr == '1) begin
                    n_epoch = lzwc_pkg::t_epoch'(1);
                    n_state = lzwc_pkg::ST_IDLE;
                end
            end
            lzwc_pkg::ST_IDLE: begin
                w_raddr = slot_hash({r_prefix, i_data_byte});
                if (w_accept) begin
                    n_byte = i_data_byte;
                    n_last = i_stream_end;
                    n_slot = w_raddr;
                    if (!r_held) begin
                        // first byte of a stream becomes the prefix
                        n_prefix = lzwc_pkg::CODE_W'(i_data_byte);
                        n_held   = 1'b1;
                        n_state  = i_stream_end ? lzwc_pkg::ST_EMIT_LAST : lzwc_pkg::ST_IDLE;
                    end else begin
                        n_state = lzwc_pkg::ST_CHECK;
                    end
                end
            end
            lzwc_pkg::ST_CHECK: begin
                priority if (w_entry_live && w_key_match) begin
                    n_prefix = w_rdata.code;
                    n_state  = r_last ? lzwc_pkg::ST_EMIT_LAST : lzwc_pkg::ST_IDLE;
                end else if (w_entry_live) begin
                    // collision: probe the next slot
                    n_slot = r_slot + AW'(1);
                end else begin
                    if (r_next_code < CW'(DICT_SIZE)) begin
                        w_we        = 1'b1;
                        n_next_code = r_next_code + CW'(1);
                    end
                    n_state = lzwc_pkg::ST_EMIT_OLD;
                end
            end
            lzwc_pkg::ST_EMIT_OLD: begin
                if (w_can_load) begin
                    n_out_valid = 1'b1;
                    n_out_code  = r_prefix;
                    n_out_last  = 1'b0;
                    n_prefix    = lzwc_pkg::CODE_W'(r_byte);
                    n_state     = r_last ? lzwc_pkg::ST_EMIT_LAST : lzwc_pkg::ST_IDLE;
                end
            end
            lzwc_pkg::ST_EMIT_LAST: begin
                if (w_can_load) begin
                    n_out_valid = 1'b1;
                    n_out_code  = r_prefix;
                    n_out_last  = 1'b1;
                    n_prefix    = '0;
                    n_held      = 1'b0;
                    n_next_code = CW'(lzwc_pkg::FIRST_CODE);
                    // a new epoch empties the table; sweep the RAM when it wraps
                    if (r_epoch == '1) begin
                        n_clr_addr = '0;
                        n_state    = lzwc_pkg::ST_CLEAR;
                    end else begin
                        n_epoch = r_epoch + lzwc_pkg::t_epoch'(1);
                        n_state = lzwc_pkg::ST_IDLE;
                    end
                end
            end
            default: begin
                n_state = lzwc_pkg::ST_CLEAR;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= lzwc_pkg::ST_CLEAR;
            r_clr_addr  <= '0;
            r_epoch     <= lzwc_pkg::t_epoch'(1);
            r_prefix    <= '0;
            r_held      <= 1'b0;
            r_next_code <= CW'(lzwc_pkg::FIRST_CODE);
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_clr_addr  <= n_clr_addr;
            r_epoch     <= n_epoch;
            r_prefix    <= n_prefix;
            r_held      <= n_held;
            r_next_code <= n_next_code;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_byte     <= n_byte;
        r_last     <= n_last;
        r_slot     <= n_slot;
        r_out_code <= n_out_code;
        r_out_last <= n_out_last;
    end

    assign o_out_valid = r_out_valid;
    assign o_code_word = r_out_code;
    assign o_code_last = r_out_last;

endmodule

// File: src/lzwc_checker.sv
// Port-level checks for the LZW compressor, bound to the top level.
`timescale 1ns / 1ps

module lzwc_checker (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          i_in_valid,
    input logic                          o_in_stall,
    input logic                          i_stream_end,
    input logic                          o_out_valid,
    input logic                          i_out_stall,
    input logic [lzwc_pkg::CODE_W-1:0]   o_code_word,
    input logic                          o_code_last
);

    // a stalled code word stays in place
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=>
            o_out_valid && $stable(o_code_word) && $stable(o_code_last))
        else $error("output word changed while stalled");

    // reset starts the clearing sweep with the input held off
    a_reset_stall: assert property (@(posedge i_clk)
        !i_rst_n |=> o_in_stall)
        else $error("input not stalled after reset");

    // the final byte always leads to a final code, so input must stall next
    a_end_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall && i_stream_end |=> o_in_stall)
        else $error("input taken right after a stream end");

endmodule

bind lzw_byte_stream_compressor lzwc_checker u_lzwc_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_in_valid   (i_in_valid),
    .o_in_stall   (o_in_stall),
    .i_stream_end (i_stream_end),
    .o_out_valid  (o_out_valid),
    .i_out_stall  (i_out_stall),
    .o_code_word  (o_code_word),
    .o_code_last  (o_code_last)
);

// File: sim/lzw_code_checker.sv
// Channel monitor for the LZW compressor: predicts the code words and compares them.
`timescale 1ns / 1ps

module lzw_code_checker #(
    parameter int DICT_SIZE = 65536
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    input  logic                        i_in_stall,
    input  logic [lzwc_pkg::BYTE_W-1:0] i_data_byte,
    input  logic                        i_stream_end,
    input  logic                        i_out_valid,
    input  logic                        i_out_stall,
    input  logic [lzwc_pkg::CODE_W-1:0] i_code_word,
    input  logic                        i_code_last,
    output int                          o_errors,
    output int                          o_pending,
    output int                          o_codes,
    output int                          o_streams,
    output int                          o_full_misses
);

    typedef struct packed {
        logic [lzwc_pkg::CODE_W-1:0] word;
        logic                        last;
    } t_code_out;

    t_code_out                   expected_codes[$];
    logic [lzwc_pkg::CODE_W-1:0] pair_code[logic [lzwc_pkg::KEY_W-1:0]];
    logic [lzwc_pkg::CODE_W:0]   free_code;
    logic [lzwc_pkg::CODE_W-1:0] cur_prefix;
    logic                        have_prefix;

    int mismatches   = 0;
    int codes_seen   = 0;
    int streams_seen = 0;
    int full_misses  = 0;

    assign o_errors      = mismatches;
    assign o_codes       = codes_seen;
    assign o_streams     = streams_seen;
    assign o_full_misses = full_misses;

    task automatic report_mismatch(input string msg);
        $display("MISMATCH at %0t ns: %s", $realtime, msg);
        mismatches++;
    endtask

    function automatic void clear_dictionary();
        pair_code.delete();
        free_code   = (lzwc_pkg::CODE_W+1)'(lzwc_pkg::FIRST_CODE);
        cur_prefix  = '0;
        have_prefix = 1'b0;
    endfunction

    task automatic compress_byte(input logic [lzwc_pkg::BYTE_W-1:0] b, input logic stream_end);
        logic [lzwc_pkg::KEY_W-1:0] key;
        if (!have_prefix) begin
            cur_prefix  = {{(lzwc_pkg::CODE_W-lzwc_pkg::BYTE_W){1'b0}}, b};
            have_prefix = 1'b1;
        end else begin
            key = {cur_prefix, b};
            if (pair_code.exists(key)) begin
                cur_prefix = pair_code[key];
            end else begin
                // Stop growing once every code is handed out.
                if (free_code < DICT_SIZE) begin
                    pair_code[key] = free_code[lzwc_pkg::CODE_W-1:0];
                    free_code++;
                end else begin
                    full_misses++;
                end
                expected_codes.push_back('{word: cur_prefix, last: 1'b0});
                cur_prefix = {{(lzwc_pkg::CODE_W-lzwc_pkg::BYTE_W){1'b0}}, b};
            end
        end
        if (stream_end) begin
            expected_codes.push_back('{word: cur_prefix, last: 1'b1});
            streams_seen++;
            clear_dictionary();
        end
    endtask

    always @(posedge i_clk) begin
        t_code_out head;
        if (!i_rst_n) begin
            clear_dictionary();
            expected_codes.delete();
        end else begin
            // Check the output word first: a byte taken now cannot produce it.
            if (i_out_valid && !i_out_stall) begin
                codes_seen++;
                if (expected_codes.size() == 0) begin
                    report_mismatch($sformatf("code word %0d (last %0b) with none expected",
                                              i_code_word, i_code_last));
                end else begin
                    head = expected_codes.pop_front();
                    if (i_code_word !== head.word)
                        report_mismatch($sformatf("code word expected %0d got %0d",
                                                  head.word, i_code_word));
                    if (i_code_last !== head.last)
                        report_mismatch($sformatf("code last expected %0b got %0b on code %0d",
                                                  head.last, i_code_last, head.word));
                end
            end
            if (i_in_valid && !i_in_stall)
                compress_byte(i_data_byte, i_stream_end);
        end
        o_pending = expected_codes.size();
    end

endmodule

// File: sim/testbench.sv
// Top of the LZW compressor testbench: clock, reset, byte streams and the verdict.
`timescale 1ns / 1ps

module testbench;

    // Small table so that the dictionary fills within a few hundred bytes.
    localparam int DICT_SIZE   = 512;
    localparam int ITEM_TARGET = 1850;
    localparam int CYCLE_LIMIT = 600000;
    localparam int QUIET_START = 3000;
    localparam int QUIET_STOP  = 6000;
    localparam int HOLD_CYCLES = 400;

    logic                        i_clk        = 1'b0;
    logic                        i_rst_n      = 1'b0;
    logic                        i_in_valid   = 1'b0;
    logic [lzwc_pkg::BYTE_W-1:0] i_data_byte  = '0;
    logic                        i_stream_end = 1'b0;
    logic                        i_out_stall  = 1'b0;
    logic                        o_in_stall;
    logic                        o_out_valid;
    logic [lzwc_pkg::CODE_W-1:0] o_code_word;
    logic                        o_code_last;

    int  errors, pending, codes, streams, full_misses;
    int  cycles = 0;
    bit  hold   = 1'b0;
    wire quiet  = (cycles >= QUIET_START) && (cycles < QUIET_STOP);

    always begin
        i_clk = 1'b0;
        #10;
        i_clk = 1'b1;
        #10;
    end

    lzw_byte_stream_compressor #(
        .DICT_SIZE(DICT_SIZE)
    ) DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_data_byte (i_data_byte),
        .i_stream_end(i_stream_end),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_code_word (o_code_word),
        .o_code_last (o_code_last)
    );

    lzw_code_checker #(
        .DICT_SIZE(DICT_SIZE)
    ) u_code_check (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .i_in_stall   (o_in_stall),
        .i_data_byte  (i_data_byte),
        .i_stream_end (i_stream_end),
        .i_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .i_code_word  (o_code_word),
        .i_code_last  (o_code_last),
        .o_errors     (errors),
        .o_pending    (pending),
        .o_codes      (codes),
        .o_streams    (streams),
        .o_full_misses(full_misses)
    );

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles with %0d codes outstanding", cycles, pending);
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // Receiver side: random stalls, none in the quiet window, solid during the hold-off.
    always @(negedge i_clk)
        i_out_stall <= hold || (!quiet && ($urandom_range(0, 99) < 20));

    // Hold off the output long enough to back the block up into its input.
    initial begin
        do @(negedge i_clk); while (codes < 150);
        @(posedge i_clk);
        hold = 1'b1;
        repeat (HOLD_CYCLES) @(posedge i_clk);
        hold = 1'b0;
    end

    // Offer one byte word, idling at random first; return at the falling edge after it is taken.
    task automatic push_byte(input logic [lzwc_pkg::BYTE_W-1:0] b, input logic last);
        while (!quiet && ($urandom_range(0, 99) < 20)) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_valid   <= 1'b1;
        i_data_byte  <= b;
        i_stream_end <= last;
        do @(posedge i_clk); while (o_in_stall);
        @(negedge i_clk);
    endtask

    initial begin
        int                          sent;
        int                          stream_no;
        int                          len;
        int                          mode;
        logic [lzwc_pkg::BYTE_W-1:0] base;
        logic [lzwc_pkg::BYTE_W-1:0] b;

        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // One-byte streams at both byte extremes.
        push_byte(8'h00, 1'b1);
        push_byte(8'hFF, 1'b1);
        // Miss on the final byte: two codes from one word.
        push_byte(8'h41, 1'b0);
        push_byte(8'h42, 1'b1);
        // Repeated byte: chained hits, ending on a hit.
        for (int i = 0; i < 6; i++)
            push_byte(8'h07, i == 5);
        // Alternate the extremes.
        for (int i = 0; i < 6; i++)
            push_byte(i[0] ? 8'hFF : 8'h00, i == 5);
        push_byte(8'h80, 1'b0);
        push_byte(8'h01, 1'b0);
        push_byte(8'h80, 1'b0);
        push_byte(8'h01, 1'b1);

        sent      = 0;
        stream_no = 0;
        while (sent < ITEM_TARGET) begin
            if (stream_no % 100 == 50) begin
                // Long stream: fill the dictionary, or build long prefixes on a narrow alphabet.
                len  = $urandom_range(300, 340);
                mode = (stream_no == 150) ? 1 : 0;
            end else begin
                len  = $urandom_range(1, 6);
                mode = $urandom_range(0, 2);
            end
            base = lzwc_pkg::BYTE_W'($urandom_range(0, 255));
            for (int j = 0; j < len; j++) begin
                case (mode)
                    0: b = lzwc_pkg::BYTE_W'($urandom_range(0, 255));
                    1: b = base + lzwc_pkg::BYTE_W'($urandom_range(0, 2));
                    default: begin
                        if ($urandom_range(0, 3) == 0)
                            base = lzwc_pkg::BYTE_W'($urandom_range(0, 255));
                        b = base;
                    end
                endcase
                push_byte(b, j == len - 1);
                sent++;
            end
            stream_no++;
        end
        i_in_valid <= 1'b0;

        while (pending != 0) @(negedge i_clk);
        repeat (40) @(negedge i_clk);

        $display("Covered %0d bytes in %0d streams, %0d code words checked.",
                 sent + 20, streams, codes);
        $display("Misses with the dictionary full: %0d; output held off for %0d cycles once.",
                 full_misses, HOLD_CYCLES);
        if (errors == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
